// ----- design/drf_pkg.sv -----
`default_nettype none

package drf_pkg;

    localparam int FRAME_W = 64;
    localparam int PKT_W   = 8;
    localparam int PULSE_W = 64;
    localparam int DEBUG_W = 32;
    localparam int DATA_W  = 64;
    localparam int ADDR_W  = 18;
    localparam int PPF_W   = 9;
    localparam int COUNT_W = 9;

    localparam int IN_TDATA_W  = 232;
    localparam int OUT_TDATA_W = 256;

    localparam logic [PPF_W-1:0]   PPF_RESET = 9'd128;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 9'd511;

    typedef enum logic [1:0] {
        KIND_WRITE = 2'd0,
        KIND_DONE  = 2'd1,
        KIND_DROP  = 2'd2
    } kind_t;

    // First member is the most significant: tdata packs frame_number lowest.
    typedef struct packed {
        logic [DATA_W-1:0]  data_word;
        logic [DEBUG_W-1:0] debug_word;
        logic [PULSE_W-1:0] bunch_id;
        logic [PKT_W-1:0]   packet_number;
        logic [FRAME_W-1:0] frame_number;
    } in_hdr_t;

    typedef struct packed {
        in_hdr_t hdr;
        logic    first_word;
        logic    last_word;
    } in_item_t;

    typedef struct packed {
        logic               last;
        kind_t              kind;
        logic [COUNT_W-1:0] received_packets;
        logic [DEBUG_W-1:0] daq_rec;
        logic [FRAME_W-1:0] done_frame;
        logic [PULSE_W-1:0] done_pulse;
        logic [DATA_W-1:0]  write_data;
        logic [ADDR_W-1:0]  write_address;
    } result_t;

endpackage

`default_nettype wire

// ----- design/detector_frame_reassembler.sv -----
`default_nettype none

// Channel   Dir  tdata (low bit first)                          tuser        tlast
// s_axis    in   frame_number, packet_number, bunch_id,         first_word   last_word
//                debug_word, data_word
// m_axis    out  write_address, write_data, done_pulse,         kind         last
//                done_frame, daq_rec, received_packets
// cfg       in   cfg_wr_data = packets_per_frame, on cfg_wr_en
//
// One payload word per cycle while the queue has room: a word is held in the
// input register, is processed against the frame state and lands in a four-entry
// result queue. A word that closes a frame, or opens a new one while a frame is
// open, yields two results; the queue holds the extra one so input can go on.
// Input is taken while the queue has room for two results; reset is async,
// active low, and clears the frame state and packets_per_frame to 128.

module detector_frame_reassembler #(
    parameter int WORDS_PER_PACKET = 1024,
    parameter int MAX_PACKETS      = 256
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,

    input  wire logic                              cfg_wr_en,
    input  wire logic [drf_pkg::PPF_W-1:0]         cfg_wr_data,

    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // frame_number, packet_number, bunch_id, debug_word, data_word
    input  wire logic [drf_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // first_word
    input  wire logic [0:0]                        s_axis_tuser,
    input  wire logic                              s_axis_tlast,

    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // write_address, write_data, done_pulse, done_frame, daq_rec, received_packets, zeros
    output logic [drf_pkg::OUT_TDATA_W-1:0]        m_axis_tdata,
    // kind
    output logic [1:0]                             m_axis_tuser,
    output logic                                   m_axis_tlast
);

    logic [drf_pkg::PPF_W-1:0] ppf_reg;
    logic                      in_valid_reg;
    drf_pkg::in_item_t         in_item_reg;
    logic                      fire;
    logic                      room;
    drf_pkg::result_t          res0;
    drf_pkg::result_t          res1;
    logic                      two_results;
    drf_pkg::result_t          out_res;

    assign fire          = in_valid_reg && room;
    assign s_axis_tready = !in_valid_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ppf_reg <= drf_pkg::PPF_RESET;
        else if (cfg_wr_en)
            ppf_reg <= cfg_wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    // hold the payload until the core takes it
    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_item_reg.hdr        <= drf_pkg::in_hdr_t'(s_axis_tdata);
            in_item_reg.first_word <= s_axis_tuser[0];
            in_item_reg.last_word  <= s_axis_tlast;
        end
    end

    drf_core #(
        .WORDS_PER_PACKET (WORDS_PER_PACKET),
        .MAX_PACKETS      (MAX_PACKETS)
    ) u_core (
        .clk               (clk),
        .rst_n             (rst_n),
        .packets_per_frame (ppf_reg),
        .item_fire         (fire),
        .item              (in_item_reg),
        .res0              (res0),
        .res1              (res1),
        .two_results       (two_results)
    );

    drf_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (fire),
        .push_two  (two_results),
        .wr0       (res0),
        .wr1       (res1),
        .room      (room),
        .pop       (m_axis_tready),
        .not_empty (m_axis_tvalid),
        .rd        (out_res)
    );

    assign m_axis_tdata = {5'b0,
                           out_res.received_packets,
                           out_res.daq_rec,
                           out_res.done_frame,
                           out_res.done_pulse,
                           out_res.write_data,
                           out_res.write_address};
    assign m_axis_tuser = out_res.kind;
    assign m_axis_tlast = out_res.last;

endmodule

`default_nettype wire

// ----- design/drf_core.sv -----
`default_nettype none

module drf_core #(
    parameter int WORDS_PER_PACKET = 1024,
    parameter int MAX_PACKETS      = 256
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic [drf_pkg::PPF_W-1:0]   packets_per_frame,
    input  wire logic                        item_fire,
    input  wire drf_pkg::in_item_t           item,
    output drf_pkg::result_t                 res0,
    output drf_pkg::result_t                 res1,
    output logic                             two_results
);

    localparam int POS_W  = (WORDS_PER_PACKET > 1) ? $clog2(WORDS_PER_PACKET) : 1;
    localparam int PROD_W = drf_pkg::PKT_W + $clog2(WORDS_PER_PACKET + 1);
    localparam logic [drf_pkg::PPF_W-1:0] MAX_PKT = drf_pkg::PPF_W'(MAX_PACKETS);
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(WORDS_PER_PACKET - 1);

    logic                          active_reg, active_next;
    logic [drf_pkg::FRAME_W-1:0]   frame_reg, frame_next;
    logic [drf_pkg::PULSE_W-1:0]   pulse_reg, pulse_next;
    logic [drf_pkg::DEBUG_W-1:0]   debug_reg, debug_next;
    logic [drf_pkg::COUNT_W-1:0]   count_reg, count_next;
    logic [POS_W-1:0]              pos_reg, pos_next;

    logic [drf_pkg::PPF_W-1:0]     limit;
    logic [drf_pkg::PPF_W-1:0]     pn9;
    logic                          drop;
    logic                          changed;
    logic                          opening;
    logic                          complete;
    logic [drf_pkg::COUNT_W-1:0]   count_base;
    logic [POS_W-1:0]              pos_cur;
    logic [PROD_W-1:0]             addr_full;
    drf_pkg::result_t              wr_res;
    drf_pkg::result_t              old_done;
    drf_pkg::result_t              new_done;
    drf_pkg::result_t              drop_res;

    always_comb
    begin
        limit   = (packets_per_frame > MAX_PKT) ? MAX_PKT : packets_per_frame;
        pn9     = drf_pkg::PPF_W'(item.hdr.packet_number);
        drop    = (pn9 >= limit);
        changed = active_reg && (item.hdr.frame_number != frame_reg);
        opening = !active_reg || changed;

        frame_next = opening ? item.hdr.frame_number : frame_reg;
        pulse_next = opening ? item.hdr.bunch_id     : pulse_reg;
        debug_next = opening ? item.hdr.debug_word   : debug_reg;
        count_base = opening ? '0 : count_reg;
        if (item.first_word && (count_base != drf_pkg::COUNT_MAX))
            count_next = count_base + 1'b1;
        else
            count_next = count_base;

        pos_cur   = item.first_word ? '0 : pos_reg;
        pos_next  = (pos_cur == POS_LAST) ? '0 : pos_cur + 1'b1;
        addr_full = PROD_W'(item.hdr.packet_number) * PROD_W'(WORDS_PER_PACKET)
                    + PROD_W'(pos_cur);

        complete    = item.last_word && ((pn9 + 1'b1) == limit) && !changed;
        active_next = !complete;

        wr_res               = '0;
        wr_res.kind          = drf_pkg::KIND_WRITE;
        wr_res.write_address = drf_pkg::ADDR_W'(addr_full);
        wr_res.write_data    = item.hdr.data_word;
        wr_res.last          = !complete;

        old_done                  = '0;
        old_done.kind             = drf_pkg::KIND_DONE;
        old_done.done_pulse       = pulse_reg;
        old_done.done_frame       = frame_reg;
        old_done.daq_rec          = debug_reg;
        old_done.received_packets = count_reg;

        new_done                  = '0;
        new_done.kind             = drf_pkg::KIND_DONE;
        new_done.done_pulse       = pulse_next;
        new_done.done_frame       = frame_next;
        new_done.daq_rec          = debug_next;
        new_done.received_packets = count_next;
        new_done.last             = 1'b1;

        drop_res      = '0;
        drop_res.kind = drf_pkg::KIND_DROP;
        drop_res.last = 1'b1;

        if (drop)
        begin
            res0        = drop_res;
            res1        = drop_res;
            two_results = 1'b0;
        end
        else if (changed)
        begin
            res0        = old_done;
            res1        = wr_res;
            two_results = 1'b1;
        end
        else
        begin
            res0        = wr_res;
            res1        = new_done;
            two_results = complete;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            frame_reg  <= '0;
            pulse_reg  <= '0;
            debug_reg  <= '0;
            count_reg  <= '0;
            pos_reg    <= '0;
        end
        else if (item_fire && !drop)
        begin
            active_reg <= active_next;
            frame_reg  <= frame_next;
            pulse_reg  <= pulse_next;
            debug_reg  <= debug_next;
            count_reg  <= count_next;
            pos_reg    <= pos_next;
        end
    end

endmodule

`default_nettype wire

// ----- design/drf_out_fifo.sv -----
`default_nettype none

module drf_out_fifo (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic             push_two,
    input  wire drf_pkg::result_t wr0,
    input  wire drf_pkg::result_t wr1,
    output logic                  room,
    input  wire logic             pop,
    output logic                  not_empty,
    output drf_pkg::result_t      rd
);

    logic [1:0]       wr_ptr_reg, wr_ptr_next;
    logic [1:0]       rd_ptr_reg, rd_ptr_next;
    logic [2:0]       count_reg, count_next;
    drf_pkg::result_t mem_reg [4];
    logic             do_pop;

    assign not_empty = (count_reg != 3'd0);
    assign room      = (count_reg <= 3'd2);
    assign rd        = mem_reg[rd_ptr_reg];
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + (push_two ? 2'd2 : 2'd1);
            count_next  = count_reg + (push_two ? 3'd2 : 3'd1);
        end
        if (do_pop)
            count_next = count_next - 3'd1;
        rd_ptr_next = do_pop ? rd_ptr_reg + 2'd1 : rd_ptr_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr0;
            if (push_two)
                mem_reg[wr_ptr_reg + 2'd1] <= wr1;
        end
    end

endmodule

`default_nettype wire
